/* hw/rtl/tle_pkg.sv */
// shared types, constants and helpers of the terminal line editor
// no dependencies; imported by every module of the block
package tle_pkg;

    localparam int LINE_MAX = 32;
    localparam int ADDR_W   = $clog2(LINE_MAX);
    localparam logic [5:0] CAP_MAX = (LINE_MAX - 1 < 31) ? 6'(LINE_MAX - 1) : 6'd31;

    localparam logic [7:0] CH_CTRL_D = 8'h04;
    localparam logic [7:0] CH_CTRL_E = 8'h05;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    localparam logic [7:0] PAT_A [5] = '{8'h7e, 8'hff, 8'h03, 8'hc0, 8'h21};
    localparam logic [7:0] PAT_B [6] = '{8'h7e, 8'hff, 8'h7d, 8'h23, 8'hc0, 8'h21};
    localparam logic [7:0] PAT_C [7] = '{8'h7e, 8'h7d, 8'hdf, 8'h7d, 8'h23, 8'hc0, 8'h21};

    typedef enum logic [2:0] {
        CFG_PPP_DETECT,
        CFG_ECHO_VISIBLE,
        CFG_LINE_SIZE,
        CFG_CHAR_LOW,
        CFG_CHAR_HIGH
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_TERM,
        KIND_LINE,
        KIND_END
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_PPP,
        ST_ABORT
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ECHO,
        S_WALK_RD,
        S_WALK_OUT,
        S_STATUS
    } t_state;

    typedef enum logic [2:0] {
        ECHO_NONE,
        ECHO_CRLF,
        ECHO_ERASE,
        ECHO_BELL,
        ECHO_CHAR
    } t_echo;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [7:0] rx;
    } t_ppp_ctl;

    function automatic logic [4:0] capacity(input logic [5:0] size);
        logic [5:0] c6;
        c6 = (size == 6'd0) ? 6'd0 : size - 6'd1;
        if (c6 > CAP_MAX) c6 = CAP_MAX;
        return c6[4:0];
    endfunction

    function automatic logic [1:0] echo_count(input t_echo code);
        case (code)
            ECHO_CRLF:  return 2'd2;
            ECHO_ERASE: return 2'd3;
            ECHO_BELL:  return 2'd1;
            ECHO_CHAR:  return 2'd1;
            default:    return 2'd0;
        endcase
    endfunction

endpackage

/* hw/rtl/tle_line_mem.sv */
// line store: one write port, one read port, registered read data
// depends on tle_pkg
module tle_line_mem (
    input  logic              i_clk,
    input  tle_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import tle_pkg::*;

    logic [7:0] mem [LINE_MAX];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tle_ppp_win.sv */
// seven-byte window and matcher for the three ppp start patterns
// depends on tle_pkg
module tle_ppp_win (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tle_pkg::t_ppp_ctl i_ctl,
    output logic              o_hit
);
    import tle_pkg::*;

    logic [7:0] r_win [7];
    logic [7:0] cand  [7];
    logic       hit_a;
    logic       hit_b;
    logic       hit_c;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            cand[k] = r_win[k+1];
        end
        cand[6] = i_ctl.rx;
        hit_a = 1'b1;
        hit_b = 1'b1;
        hit_c = 1'b1;
        for (int j = 0; j < 5; j++) begin
            if (cand[2+j] != PAT_A[j]) hit_a = 1'b0;
        end
        for (int j = 0; j < 6; j++) begin
            if (cand[1+j] != PAT_B[j]) hit_b = 1'b0;
        end
        for (int j = 0; j < 7; j++) begin
            if (cand[j] != PAT_C[j]) hit_c = 1'b0;
        end
    end

    assign o_hit = hit_a | hit_b | hit_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int k = 0; k < 7; k++) r_win[k] <= 8'd0;
        end else if (i_ctl.shift) begin
            for (int k = 0; k < 7; k++) r_win[k] <= cand[k];
        end
    end

endmodule

/* hw/rtl/terminal_line_editor_ppp_detect.sv */
// terminal line editor with ppp start detection, top level
// depends on tle_pkg, tle_line_mem, tle_ppp_win
//
// usage: received terminal bytes enter on i_valid/o_ready/i_rx_byte, one beat
// per byte. result beats leave on o_valid/i_ready with kind, byte, status,
// line length and a last flag on the final beat caused by a byte. registers
// are written on the cfg channel (i_cfg_valid/o_cfg_ready, index, data),
// which is always ready and should only be used while the editor is idle.
// timing: an accepted byte is decoded in the cycle after acceptance; each echo
// or status beat is then loaded into the output register, and each stored line
// character is read from the line store, whose read data is registered, then output.
// o_ready returns in the cycle after the last beat enters the output register.
// the output register parts both sides: the next byte is taken while the
// final beat still waits for i_ready; a stalled receiver holds the beat and
// freezes the walk.
// reset: registers take their defaults, the line is empty, newline echo on,
// ppp window cleared; the line store is not cleared, only written entries
// are ever read.
module terminal_line_editor_ppp_detect (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic [4:0] o_line_length,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import tle_pkg::*;

    logic       r_ppp;
    logic       r_echo_vis;
    logic [5:0] r_line_size;
    logic [7:0] r_char_low;
    logic [7:0] r_char_high;

    t_state     r_state, n_state;
    logic [4:0] r_fill, n_fill;
    logic       r_cr, n_cr;
    logic       r_nl_echo, n_nl_echo;
    t_echo      r_echo, n_echo;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_echo_char, n_echo_char;
    logic       r_stat_en, n_stat_en;
    t_status    r_stat, n_stat;
    logic [4:0] r_len, n_len;
    logic [4:0] r_widx, n_widx;
    logic [7:0] r_byte;

    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_obyte;
    logic [1:0] r_ostat;
    logic [4:0] r_olen;
    logic       r_olast;

    logic       out_free;
    logic       out_load;
    t_kind      ld_kind;
    logic [7:0] ld_byte;
    t_status    ld_stat;
    logic [4:0] ld_len;
    logic       ld_last;
    logic       echo_end;
    logic [7:0] echo_byte;

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    t_ppp_ctl   ppp_ctl;
    logic       ppp_hit;

    tle_line_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    tle_ppp_win u_ppp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ppp_ctl),
        .o_hit   (ppp_hit)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppp       <= 1'b0;
            r_echo_vis  <= 1'b1;
            r_line_size <= 6'd32;
            r_char_low  <= 8'd32;
            r_char_high <= 8'd126;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PPP_DETECT:   r_ppp       <= i_cfg_data[0];
                CFG_ECHO_VISIBLE: r_echo_vis  <= i_cfg_data[0];
                CFG_LINE_SIZE:    r_line_size <= i_cfg_data[5:0];
                CFG_CHAR_LOW:     r_char_low  <= i_cfg_data;
                CFG_CHAR_HIGH:    r_char_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign echo_end = (r_idx == echo_count(r_echo) - 2'd1);

    always_comb begin
        case (r_echo)
            ECHO_CRLF:  echo_byte = (r_idx == 2'd0) ? CH_CR : CH_LF;
            ECHO_ERASE: echo_byte = (r_idx == 2'd1) ? CH_SP : CH_BS;
            ECHO_BELL:  echo_byte = CH_BEL;
            ECHO_CHAR:  echo_byte = r_echo_char;
            default:    echo_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cr        = r_cr;
        n_nl_echo   = r_nl_echo;
        n_echo      = r_echo;
        n_idx       = r_idx;
        n_echo_char = r_echo_char;
        n_stat_en   = r_stat_en;
        n_stat      = r_stat;
        n_len       = r_len;
        n_widx      = r_widx;
        mem_req     = '0;
        ppp_ctl     = '{shift: 1'b0, clear: 1'b0, rx: r_byte};
        out_load    = 1'b0;
        ld_kind     = KIND_TERM;
        ld_byte     = 8'd0;
        ld_stat     = ST_DONE;
        ld_len      = 5'd0;
        ld_last     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_echo    = ECHO_NONE;
                n_idx     = 2'd0;
                n_stat_en = 1'b0;
                n_stat    = ST_DONE;
                n_len     = 5'd0;
                n_widx    = 5'd0;
                ppp_ctl.shift = r_ppp;
                if (r_ppp && ppp_hit) begin
                    ppp_ctl.clear = 1'b1;
                    n_stat_en = 1'b1;
                    n_stat    = ST_PPP;
                    n_fill    = 5'd0;
                    n_nl_echo = 1'b1;
                end else if (r_byte == CH_LF && r_cr) begin
                    n_cr = 1'b0;
                end else begin
                    n_cr = (r_byte == CH_CR);
                    case (r_byte)
                        CH_LF, CH_CR: begin
                            ppp_ctl.clear = 1'b1;
                            n_echo    = r_nl_echo ? ECHO_CRLF : ECHO_NONE;
                            n_stat_en = 1'b1;
                            n_len     = r_fill;
                            n_fill    = 5'd0;
                            n_nl_echo = 1'b1;
                        end
                        CH_CTRL_D: begin
                            if (r_fill == 5'd0) begin
                                ppp_ctl.clear = 1'b1;
                                n_echo    = r_nl_echo ? ECHO_CRLF : ECHO_NONE;
                                n_stat_en = 1'b1;
                                n_stat    = ST_ABORT;
                                n_nl_echo = 1'b1;
                            end
                        end
                        CH_CTRL_E: begin
                            n_nl_echo = 1'b0;
                        end
                        CH_BS, CH_DEL: begin
                            if (r_fill == 5'd0) begin
                                n_echo = ECHO_BELL;
                            end else begin
                                n_echo = ECHO_ERASE;
                                n_fill = r_fill - 5'd1;
                            end
                        end
                        default: begin
                            if (r_byte < r_char_low || r_byte > r_char_high
                                || r_fill >= capacity(r_line_size)) begin
                                n_echo = ECHO_BELL;
                            end else begin
                                n_echo        = ECHO_CHAR;
                                n_echo_char   = r_echo_vis ? r_byte : CH_STAR;
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ADDR_W'(r_fill);
                                mem_req.wdata = r_byte;
                                n_fill        = r_fill + 5'd1;
                            end
                        end
                    endcase
                end
                if (n_echo != ECHO_NONE) begin
                    n_state = S_ECHO;
                end else if (n_stat_en) begin
                    n_state = (n_len != 5'd0) ? S_WALK_RD : S_STATUS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ECHO: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_kind  = KIND_TERM;
                    ld_byte  = echo_byte;
                    ld_last  = echo_end && !r_stat_en;
                    n_idx    = r_idx + 2'd1;
                    if (echo_end) begin
                        if (!r_stat_en) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = (r_len != 5'd0) ? S_WALK_RD : S_STATUS;
                        end
                    end
                end
            end
            S_WALK_RD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ADDR_W'(r_widx);
                n_state       = S_WALK_OUT;
            end
            S_WALK_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_kind  = KIND_LINE;
                    ld_byte  = mem_rdata;
                    n_widx   = r_widx + 5'd1;
                    n_state  = (r_widx + 5'd1 == r_len) ? S_STATUS : S_WALK_RD;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_kind  = KIND_END;
                    ld_stat  = r_stat;
                    ld_len   = r_len;
                    ld_last  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 5'd0;
            r_cr        <= 1'b0;
            r_nl_echo   <= 1'b1;
            r_echo      <= ECHO_NONE;
            r_idx       <= 2'd0;
            r_stat_en   <= 1'b0;
            r_stat      <= ST_DONE;
            r_len       <= 5'd0;
            r_widx      <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cr        <= n_cr;
            r_nl_echo   <= n_nl_echo;
            r_echo      <= n_echo;
            r_idx       <= n_idx;
            r_stat_en   <= n_stat_en;
            r_stat      <= n_stat;
            r_len       <= n_len;
            r_widx      <= n_widx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_echo_char <= n_echo_char;
        if (i_valid && o_ready) begin
            r_byte <= i_rx_byte;
        end
        if (out_load) begin
            r_kind  <= ld_kind;
            r_obyte <= ld_byte;
            r_ostat <= ld_stat;
            r_olen  <= ld_len;
            r_olast <= ld_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_byte    = r_obyte;
    assign o_status      = r_ostat;
    assign o_line_length = r_olen;
    assign o_last        = r_olast;

endmodule

/* hw/rtl/tle_checker.sv */
// port-level checks of the terminal line editor, bound to the top level
// depends on tle_pkg and terminal_line_editor_ppp_detect
module tle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_out_byte,
    input logic [1:0] o_status,
    input logic [4:0] o_line_length,
    input logic       o_last
);
    import tle_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_out_byte)
            && $stable(o_last))
        else $error("stalled result beat changed");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind == KIND_TERM || o_kind == KIND_LINE || o_kind == KIND_END)
        else $error("result beat with unused kind");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_END |-> o_last && o_out_byte == 8'd0
            && (o_status == ST_DONE || o_line_length == 5'd0))
        else $error("malformed end status beat");

    a_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_END |-> o_status == ST_DONE && o_line_length == 5'd0
            && !(o_kind == KIND_LINE && o_last))
        else $error("echo or line beat carries status fields");

endmodule

bind terminal_line_editor_ppp_detect tle_checker u_tle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kind        (o_kind),
    .o_out_byte    (o_out_byte),
    .o_status      (o_status),
    .o_line_length (o_line_length),
    .o_last        (o_last)
);
